// ===== sv/gzfs_pkg.sv =====
package gzfs_pkg;

  localparam int DIM_W       = 12;
  localparam int COUNT_W     = 21;
  localparam int ZONE_W      = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int GRID_SIDE   = 3;
  localparam int ZONE_TOTAL  = GRID_SIDE * GRID_SIDE;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0]     DIM_MIN       = DIM_W'(GRID_SIDE);
  localparam logic [DIM_W-1:0]     MAX_DIMENSION = 12'd4095;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [ZONE_W-1:0]    CENTER_ZONE   = 4'd5;

  // floor(x/3) for x < 4096 is (x * 2731) >> 13
  localparam int                   RECIP_SHIFT   = 13;
  localparam logic [RECIP_SHIFT-1:0] RECIP_THIRD = 13'd2731;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS    = 1'd1;

  localparam logic [DIM_W-1:0] RESET_COLUMNS = 12'd640;
  localparam logic [DIM_W-1:0] RESET_ROWS    = 12'd480;

  // geometry of one frame side, worked out on reset and when the register is written
  typedef struct packed {
    logic [DIM_W-1:0] last;   // clamped size minus one
    logic [DIM_W-1:0] zw;     // zone extent
    logic [DIM_W-1:0] zw2;    // two zone extents
    logic [DIM_W-1:0] trim;   // three zone extents
  } dim_t;

  // word handed from the front to the back
  typedef struct packed {
    logic              inc;   // count one free pixel in zone
    logic [ZONE_W-1:0] zone;  // zone index, 0 .. 8
    logic              last;  // last pixel of the frame
  } q_word_t;

  function automatic dim_t derive_dim(logic [DIM_W-1:0] v);
    logic [DIM_W-1:0]             c;
    logic [DIM_W+RECIP_SHIFT-1:0] prod;
    logic [DIM_W-1:0]             third;
    dim_t                         d;
    c = v;
    if (v < DIM_MIN) begin
      c = DIM_MIN;
    end else if (v > MAX_DIMENSION) begin
      c = MAX_DIMENSION;
    end
    prod   = (DIM_W+RECIP_SHIFT)'(c) * (DIM_W+RECIP_SHIFT)'(RECIP_THIRD);
    third  = prod[DIM_W+RECIP_SHIFT-1:RECIP_SHIFT];
    d.last = c - DIM_W'(1);
    d.zw   = third;
    d.zw2  = DIM_W'({third, 1'b0});
    d.trim = DIM_W'({third, 1'b0}) + third;
    return d;
  endfunction

endpackage

// ===== sv/gzfs_front.sv =====
module gzfs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gzfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gzfs_pkg::DIM_W-1:0]     cfg_data,
  input  logic                           push,
  input  logic [7:0]                     pixel_value,
  input  logic                           q_full,
  output logic                           q_wr,
  output gzfs_pkg::q_word_t              q_wdata
);
  import gzfs_pkg::*;

  dim_t             col_dim;
  dim_t             row_dim;
  logic [DIM_W-1:0] column_position;
  logic [DIM_W-1:0] row_position;

  logic       row_end;
  logic       frame_end;
  logic       in_area;
  logic [1:0] zc;
  logic [1:0] zr;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_dim <= derive_dim(RESET_COLUMNS);
      row_dim <= derive_dim(RESET_ROWS);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_COLUMNS: col_dim <= derive_dim(cfg_data);
        CFG_FRAME_ROWS:    row_dim <= derive_dim(cfg_data);
        default:           ;
      endcase
    end
  end

  always_comb begin
    in_area   = (column_position < col_dim.trim) && (row_position < row_dim.trim);
    row_end   = column_position >= col_dim.last;
    frame_end = row_end && (row_position >= row_dim.last);
    priority if (column_position < col_dim.zw) begin
      zc = 2'd0;
    end else if (column_position < col_dim.zw2) begin
      zc = 2'd1;
    end else begin
      zc = 2'd2;
    end
    priority if (row_position < row_dim.zw) begin
      zr = 2'd0;
    end else if (row_position < row_dim.zw2) begin
      zr = 2'd1;
    end else begin
      zr = 2'd2;
    end
    q_wr         = push && !q_full;
    q_wdata.inc  = (pixel_value != 8'd0) && in_area;
    q_wdata.zone = ZONE_W'({zr, 1'b0}) + ZONE_W'(zr) + ZONE_W'(zc);
    q_wdata.last = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
    end else if (q_wr) begin
      priority if (frame_end) begin
        column_position <= '0;
        row_position    <= '0;
      end else if (row_end) begin
        column_position <= '0;
        row_position    <= row_position + DIM_W'(1);
      end else begin
        column_position <= column_position + DIM_W'(1);
      end
    end
  end

endmodule

// ===== sv/gzfs_fifo.sv =====
module gzfs_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  gzfs_pkg::q_word_t wdata,
  input  logic              rd,
  output gzfs_pkg::q_word_t rdata,
  output logic              full,
  output logic              empty
);
  import gzfs_pkg::*;

  q_word_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full  = fill == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({wr, rd})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/gzfs_back.sv =====
module gzfs_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gzfs_pkg::q_word_t            q_head,
  input  logic                         q_empty,
  output logic                         q_rd,
  input  logic                         pop,
  output logic                         empty,
  output logic [gzfs_pkg::ZONE_W-1:0]  best_zone,
  output logic [1:0]                   thrust_code,
  output logic [1:0]                   roll_code,
  output logic [gzfs_pkg::COUNT_W-1:0] best_count
);
  import gzfs_pkg::*;

  typedef enum logic [2:0] {
    SC_IDLE = 3'b001,
    SC_RUN  = 3'b010,
    SC_HOLD = 3'b100
  } scan_state_t;

  localparam logic [ZONE_W-1:0] LAST_IDX = ZONE_W'(ZONE_TOTAL - 1);

  scan_state_t        scan_state;
  logic [ZONE_W-1:0]  scan_idx;
  logic [COUNT_W-1:0] most;
  logic [ZONE_W-1:0]  best;
  logic [COUNT_W-1:0] counts     [ZONE_TOTAL];
  logic [COUNT_W-1:0] count_next [ZONE_TOTAL];
  logic [COUNT_W-1:0] snap       [ZONE_TOTAL];
  logic               out_valid;
  logic               out_free;
  logic               frame_done;

  function automatic logic [3:0] zone_codes(logic [ZONE_W-1:0] z);
    logic [3:0] rc;
    unique case (z)
      4'd1:    rc = {2'd0, 2'd0};
      4'd2:    rc = {2'd0, 2'd1};
      4'd3:    rc = {2'd0, 2'd2};
      4'd4:    rc = {2'd1, 2'd0};
      4'd6:    rc = {2'd1, 2'd2};
      4'd7:    rc = {2'd2, 2'd0};
      4'd8:    rc = {2'd2, 2'd1};
      4'd9:    rc = {2'd2, 2'd2};
      default: rc = {2'd1, 2'd1};
    endcase
    return rc;
  endfunction

  always_comb begin
    q_rd       = !q_empty && (!q_head.last || scan_state == SC_IDLE);
    frame_done = q_rd && q_head.last;
    out_free   = !out_valid || pop;
    empty      = !out_valid;
    for (int k = 0; k < ZONE_TOTAL; k++) begin
      if (q_rd && q_head.inc && q_head.zone == ZONE_W'(k) && counts[k] != COUNT_MAX) begin
        count_next[k] = counts[k] + COUNT_W'(1);
      end else begin
        count_next[k] = counts[k];
      end
    end
  end

  // zone counters, cleared as the frame's totals move to the scan bank
  always_ff @(posedge clk) begin
    for (int k = 0; k < ZONE_TOTAL; k++) begin
      if (rst || frame_done) begin
        counts[k] <= '0;
      end else begin
        counts[k] <= count_next[k];
      end
    end
  end

  // scan bank shifts toward entry zero, one compare a cycle
  always_ff @(posedge clk) begin
    if (frame_done) begin
      for (int k = 0; k < ZONE_TOTAL; k++) begin
        snap[k] <= count_next[k];
      end
    end else if (scan_state == SC_RUN) begin
      for (int k = 0; k < ZONE_TOTAL - 1; k++) begin
        snap[k] <= snap[k+1];
      end
      snap[ZONE_TOTAL-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= SC_IDLE;
      scan_idx   <= '0;
      most       <= '0;
      best       <= CENTER_ZONE;
    end else begin
      unique case (scan_state)
        SC_IDLE: begin
          if (frame_done) begin
            scan_state <= SC_RUN;
            scan_idx   <= '0;
            most       <= '0;
            best       <= CENTER_ZONE;
          end
        end
        SC_RUN: begin
          if (snap[0] > most) begin
            most <= snap[0];
            best <= scan_idx + ZONE_W'(1);
          end
          scan_idx <= scan_idx + ZONE_W'(1);
          if (scan_idx == LAST_IDX) begin
            scan_state <= SC_HOLD;
          end
        end
        SC_HOLD: begin
          if (out_free) begin
            scan_state <= SC_IDLE;
          end
        end
        default: scan_state <= SC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_state == SC_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_state == SC_HOLD && out_free) begin
      best_zone                <= best;
      best_count               <= most;
      {thrust_code, roll_code} <= zone_codes(best);
    end
  end

  a_scan_idx_range: assert property (@(posedge clk) disable iff (rst)
    scan_state == SC_RUN |-> scan_idx <= LAST_IDX)
    else $error("scan index past last zone");

  a_counts_cleared: assert property (@(posedge clk) disable iff (rst)
    frame_done |=> counts[0] == '0 && counts[ZONE_TOTAL-1] == '0)
    else $error("zone counters not cleared at frame end");

  a_empty_frame_center: assert property (@(posedge clk) disable iff (rst)
    out_valid && best_count == '0 |-> best_zone == CENTER_ZONE)
    else $error("empty frame did not select center zone");

  a_result_from_hold: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(scan_state == SC_HOLD))
    else $error("result appeared without a finished scan");

endmodule

// ===== sv/grid_zone_free_space_select.sv =====
// result path: the last pixel word of a frame starts the winner scan, then the result waits
//   in the hold state until the result slot is free
// throughput: one pixel word per cycle while the queue is not full; the nine-step winner scan
//   runs once per frame, and a frame's last word waits in the 4-word queue until the previous scan is done
// reset: synchronous on rst; frame size returns to 640x480, positions and zone counts
//   clear, the pixel queue and the result slot come up empty
module grid_zone_free_space_select (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [gzfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gzfs_pkg::DIM_W-1:0]     cfg_data,
  // pixel side
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     pixel_value,
  // result side
  output logic                           empty,
  input  logic                           pop,
  output logic [gzfs_pkg::ZONE_W-1:0]    best_zone,
  output logic [1:0]                     thrust_code,
  output logic [1:0]                     roll_code,
  output logic [gzfs_pkg::COUNT_W-1:0]   best_count
);
  import gzfs_pkg::*;

  // front to queue
  logic    q_wr;
  q_word_t q_wdata;
  logic    q_full;
  // queue to back
  logic    q_rd;
  q_word_t q_head;
  logic    q_empty;

  // front: tracks raster position, picks the zone by compare against zone edges
  gzfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .pixel_value (pixel_value),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata)
  );

  // short queue so the front keeps taking pixels while the back waits on a scan
  gzfs_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  // back: saturating zone counters, winner scan, one-word result slot
  gzfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .best_zone   (best_zone),
    .thrust_code (thrust_code),
    .roll_code   (roll_code),
    .best_count  (best_count)
  );

  // a pixel word is refused only while the queue is full
  assign full = q_full;

endmodule
